/* design/segment_tree_range_query_core_macros.svh */
// Assertion macros shared by the segment tree core
`ifndef SEGMENT_TREE_RANGE_QUERY_CORE_MACROS_SVH
`define SEGMENT_TREE_RANGE_QUERY_CORE_MACROS_SVH

// same-cycle implication
`define STQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/stq_pkg.sv */
// Types, constants and helpers shared by the segment tree core
`default_nettype none

package stq_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int VALUE_W     = 32;
  localparam int LEAF_W      = $clog2(MAX_ENTRIES);
  localparam int NODE_COUNT  = 2 * MAX_ENTRIES;
  localparam int NODE_W      = LEAF_W + 1;
  localparam int ACT_W       = LEAF_W + 1;
  localparam int CFG_DATA_W  = ACT_W;
  localparam int STK_W       = 4;
  localparam int STK_DEPTH   = 2 ** STK_W;

  typedef enum logic [1:0] {
    MODE_SUM = 2'd0,
    MODE_MIN = 2'd1,
    MODE_MAX = 2'd2
  } mode_t;

  localparam logic REG_COMBINE_MODE   = 1'b0;
  localparam logic REG_ACTIVE_ENTRIES = 1'b1;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic              func;
    logic [LEAF_W-1:0] first;
    logic [LEAF_W-1:0] last;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] result;
  } resp_t;

  typedef struct packed {
    logic               we;
    logic [NODE_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic [NODE_W-1:0]  raddr;
  } ram_req_t;

  function automatic logic [VALUE_W-1:0] mode_identity(input mode_t m);
    logic [VALUE_W-1:0] id;
    case (m)
      MODE_MIN: id = {1'b0, {(VALUE_W-1){1'b1}}};
      MODE_MAX: id = {1'b1, {(VALUE_W-1){1'b0}}};
      default:  id = '0;
    endcase
    return id;
  endfunction

endpackage

`default_nettype wire

/* design/stq_join.sv */
// Shared combine unit: wrapping add, signed minimum or signed maximum
`default_nettype none

module stq_join import stq_pkg::*; (
  input  mode_t              mode,
  input  logic [VALUE_W-1:0] a,
  input  logic [VALUE_W-1:0] b,
  output logic [VALUE_W-1:0] y
);

  logic a_less;

  assign a_less = $signed(a) < $signed(b);

  always_comb begin
    case (mode)
      MODE_MIN: y = a_less ? a : b;
      MODE_MAX: y = a_less ? b : a;
      default:  y = a + b;
    endcase
  end

endmodule

`default_nettype wire

/* design/stq_node_ram.sv */
// Node store: one write port, one registered read port
`default_nettype none

module stq_node_ram import stq_pkg::*; (
  input  logic               clk,
  input  ram_req_t           req,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

/* design/stq_ctrl.sv */
// Sequencer: clearing sweep, point update walk and stack-driven range query
`default_nettype none
`include "segment_tree_range_query_core_macros.svh"

module stq_ctrl import stq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mode_t              mode,
  input  logic [ACT_W-1:0]   active,
  input  logic               clear_start,
  input  logic               start,
  input  item_t              item,
  input  logic               out_free,
  input  logic [VALUE_W-1:0] rdata,
  output ram_req_t           ram_req,
  output logic               idle,
  output logic               done_fire,
  output resp_t              resp
);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_UPD_DOWN = 7'b0000100,
    S_UPD_SIB  = 7'b0001000,
    S_UPD_JOIN = 7'b0010000,
    S_QRY_POP  = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [NODE_W-1:0]  clr_cnt, clr_cnt_next;
  logic [NODE_W-1:0]  k, k_next;
  logic [LEAF_W-1:0]  s, s_next;
  logic [LEAF_W-1:0]  e, e_next;
  logic [LEAF_W-1:0]  first, first_next;
  logic [LEAF_W-1:0]  last, last_next;
  logic               func, func_next;
  logic [VALUE_W-1:0] val, val_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               status, status_next;
  logic               rd_pend, rd_pend_next;
  logic [STK_W:0]     sp, sp_next;

  logic [NODE_W-1:0]  stk_k [STK_DEPTH];
  logic [LEAF_W-1:0]  stk_s [STK_DEPTH];
  logic [LEAF_W-1:0]  stk_e [STK_DEPTH];

  logic [STK_W-1:0]   top_idx;
  logic [NODE_W-1:0]  q_k;
  logic [LEAF_W-1:0]  q_s, q_e, q_mid, u_mid;
  logic [LEAF_W:0]    q_sum, u_sum;
  logic               q_out, q_in, q_split;
  logic [LEAF_W-1:0]  e_top;
  logic               upd_bad, qry_bad, push_root;
  logic [VALUE_W-1:0] j_a, j_y;

  stq_join u_join (
    .mode (mode),
    .a    (j_a),
    .b    (rdata),
    .y    (j_y)
  );

  assign e_top   = LEAF_W'(active - 1'b1);
  assign upd_bad = {1'b0, item.first} >= active;
  assign qry_bad = ({1'b0, item.last} >= active) || (item.first > item.last);
  assign push_root = (state == S_IDLE) && start && (item.func == FUNC_QUERY) && !qry_bad;

  // top of the query stack
  assign top_idx = STK_W'(sp - 1'b1);
  assign q_k     = stk_k[top_idx];
  assign q_s     = stk_s[top_idx];
  assign q_e     = stk_e[top_idx];
  assign q_sum   = {1'b0, q_s} + {1'b0, q_e};
  assign q_mid   = q_sum[LEAF_W:1];
  assign q_out   = (last < q_s) || (q_e < first);
  assign q_in    = (first <= q_s) && (q_e <= last);
  assign q_split = (state == S_QRY_POP) && (sp != '0) && !q_out && !q_in;

  assign u_sum = {1'b0, s} + {1'b0, e};
  assign u_mid = u_sum[LEAF_W:1];

  assign j_a = (state == S_UPD_JOIN) ? val : acc;

  assign idle      = (state == S_IDLE);
  assign done_fire = (state == S_DONE) && out_free;
  assign resp.status = status;
  assign resp.result = (status == STATUS_OK && func == FUNC_QUERY) ? acc : '0;

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = k;
    ram_req.wdata = val;
    ram_req.raddr = k;
    case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt;
        ram_req.wdata = mode_identity(mode);
      end
      S_UPD_DOWN: begin
        ram_req.we = (s == e);
      end
      S_UPD_SIB: begin
        ram_req.raddr = {k[NODE_W-1:1], ~k[0]};
      end
      S_UPD_JOIN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = {1'b0, k[NODE_W-1:1]};
        ram_req.wdata = j_y;
      end
      S_QRY_POP: begin
        ram_req.raddr = q_k;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    k_next       = k;
    s_next       = s;
    e_next       = e;
    first_next   = first;
    last_next    = last;
    func_next    = func;
    val_next     = val;
    acc_next     = acc;
    status_next  = status;
    rd_pend_next = 1'b0;
    sp_next      = sp;
    case (state)
      S_CLEAR: begin
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == NODE_W'(NODE_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          first_next  = item.first;
          last_next   = item.last;
          func_next   = item.func;
          val_next    = item.value;
          acc_next    = mode_identity(mode);
          k_next      = NODE_W'(1);
          s_next      = '0;
          e_next      = e_top;
          status_next = STATUS_OK;
          if (item.func == FUNC_UPDATE) begin
            if (upd_bad) begin
              status_next = STATUS_BAD;
              state_next  = S_DONE;
            end else begin
              state_next = S_UPD_DOWN;
            end
          end else begin
            if (qry_bad) begin
              status_next = STATUS_BAD;
              state_next  = S_DONE;
            end else begin
              sp_next    = (STK_W+1)'(1);
              state_next = S_QRY_POP;
            end
          end
        end
      end
      S_UPD_DOWN: begin
        if (s == e) begin
          state_next = (k == NODE_W'(1)) ? S_DONE : S_UPD_SIB;
        end else if (first <= u_mid) begin
          k_next = {k[NODE_W-2:0], 1'b0};
          e_next = u_mid;
        end else begin
          k_next = {k[NODE_W-2:0], 1'b1};
          s_next = u_mid + 1'b1;
        end
      end
      S_UPD_SIB: begin
        state_next = S_UPD_JOIN;
      end
      S_UPD_JOIN: begin
        val_next   = j_y;
        k_next     = {1'b0, k[NODE_W-1:1]};
        state_next = (k[NODE_W-1:1] == (NODE_W-1)'(1)) ? S_DONE : S_UPD_SIB;
      end
      S_QRY_POP: begin
        if (rd_pend) begin
          acc_next = j_y;
        end
        if (sp == '0) begin
          state_next = S_DONE;
        end else if (q_out) begin
          sp_next = sp - 1'b1;
        end else if (q_in) begin
          sp_next      = sp - 1'b1;
          rd_pend_next = 1'b1;
        end else begin
          sp_next = sp + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (clear_start) begin
      state_next   = S_CLEAR;
      clr_cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      sp      <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      sp      <= sp_next;
      rd_pend <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    k      <= k_next;
    s      <= s_next;
    e      <= e_next;
    first  <= first_next;
    last   <= last_next;
    func   <= func_next;
    val    <= val_next;
    acc    <= acc_next;
    status <= status_next;
  end

  // partial node: right child replaces the top, left child goes above it
  always_ff @(posedge clk) begin
    if (push_root) begin
      stk_k[0] <= NODE_W'(1);
      stk_s[0] <= '0;
      stk_e[0] <= e_top;
    end else if (q_split) begin
      stk_k[top_idx]          <= {q_k[NODE_W-2:0], 1'b1};
      stk_s[top_idx]          <= q_mid + 1'b1;
      stk_e[top_idx]          <= q_e;
      stk_k[sp[STK_W-1:0]]    <= {q_k[NODE_W-2:0], 1'b0};
      stk_s[sp[STK_W-1:0]]    <= q_s;
      stk_e[sp[STK_W-1:0]]    <= q_mid;
    end
  end

  `STQ_ASSERT_SAME(a_stack_room, clk, rst, state == S_QRY_POP, sp < (STK_W+1)'(STK_DEPTH), "query stack overflow")
  `STQ_ASSERT_SAME(a_sib_below_root, clk, rst, state == S_UPD_SIB, k > NODE_W'(1), "update ascent passed the root")
  `STQ_ASSERT_NEXT(a_query_ends, clk, rst, state == S_QRY_POP && sp == '0 && !clear_start, state == S_DONE, "query walk did not finish")
  `STQ_ASSERT_SAME(a_bad_is_zero, clk, rst, done_fire && resp.status == STATUS_BAD, resp.result == '0, "error word carries a value")

endmodule

`default_nettype wire

/* design/segment_tree_range_query_core.sv */
// Top level of the segment tree core: config registers, node store, sequencer, output register
//
//  channel  direction  handshake                 payload
//  in       to core    in_valid / in_stall       func, first_index, last_index, new_value
//  out      from core  out_valid / out_stall     status, result_value
//  cfg      to core    cfg_write_en              cfg_index, cfg_data
//
// Update word: one step per level down (depth = ceil(log2(active_entries))), then a sibling
//   read and a parent write per level up, split as the store read is registered. The next
//   word is taken only once the walk is done and its result has gone to the output register.
// Query word: a stack-driven walk over the visited nodes (at most about four per level).
// Reset and every config write sweep the store to the mode identity, one node per cycle,
//   with in_stall high. A done word waits only for a full, stalled output reg.
`default_nettype none

module segment_tree_range_query_core import stq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     func,
  input  logic [LEAF_W-1:0]        first_index,
  input  logic [LEAF_W-1:0]        last_index,
  input  logic signed [VALUE_W-1:0] new_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     status,
  output logic signed [VALUE_W-1:0] result_value,
  input  logic                     cfg_write_en,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  mode_t              mode;
  logic [ACT_W-1:0]   active;
  item_t              item;
  resp_t              resp;
  ram_req_t           ram_req;
  logic [VALUE_W-1:0] rdata;
  logic               ctrl_idle;
  logic               start;
  logic               done_fire;
  logic               out_free;

  // config registers; mode 3 folds to sum, entry count clamps to 1..MAX_ENTRIES
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_SUM;
      active <= ACT_W'(MAX_ENTRIES);
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_COMBINE_MODE: begin
          mode <= (cfg_data[1:0] == 2'd3) ? MODE_SUM : mode_t'(cfg_data[1:0]);
        end
        REG_ACTIVE_ENTRIES: begin
          if (cfg_data == '0) begin
            active <= ACT_W'(1);
          end else if (cfg_data > CFG_DATA_W'(MAX_ENTRIES)) begin
            active <= ACT_W'(MAX_ENTRIES);
          end else begin
            active <= ACT_W'(cfg_data);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall = rst || !ctrl_idle;
  assign start    = in_valid && !in_stall;

  assign item.func  = func;
  assign item.first = first_index;
  assign item.last  = last_index;
  assign item.value = $unsigned(new_value);

  // output slot frees when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  stq_node_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  stq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .active      (active),
    .clear_start (cfg_write_en),
    .start       (start),
    .item        (item),
    .out_free    (out_free),
    .rdata       (rdata),
    .ram_req     (ram_req),
    .idle        (ctrl_idle),
    .done_fire   (done_fire),
    .resp        (resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      status       <= resp.status;
      result_value <= $signed(resp.result);
    end
  end

endmodule

`default_nettype wire

/* bench/segment_tree_range_query_core_tb.sv */
// Self-checking bench for segment_tree_range_query_core: random point updates and range queries
`timescale 1ns / 100ps

module segment_tree_range_query_core_tb import stq_pkg::*;;

  // Watchdog limit: a store sweep after a config write plus one slow query under the
  // longest output stall stays well below this many quiet cycles.
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int WORDS_PER_PHASE = 92;
  localparam int NUM_PHASES      = 8;
  // Mode encoding 3 is not in mode_t; the core treats it as sum.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Tracks leaf values and the register state, predicts one result word per input word.
  // Range combines are folded directly over the leaves: sum mod 2^32, min and max are
  // associative, so this matches whatever tree shape the core uses.
  class range_combine_checker;
    mode_t              mode;
    int                 active_count;
    logic [VALUE_W-1:0] leaf_value [MAX_ENTRIES];
    resp_t              pending_resp [$];
    int                 mismatches;
    int                 n_update;
    int                 n_query;
    int                 n_reject;
    int                 n_checked;

    function new();
      mode         = MODE_SUM;
      active_count = MAX_ENTRIES;
      clear_leaves();
    endfunction

    function logic [VALUE_W-1:0] identity();
      case (mode)
        MODE_MIN: return {1'b0, {(VALUE_W-1){1'b1}}};
        MODE_MAX: return {1'b1, {(VALUE_W-1){1'b0}}};
        default:  return '0;
      endcase
    endfunction

    function void clear_leaves();
      foreach (leaf_value[i]) leaf_value[i] = identity();
    endfunction

    function logic [VALUE_W-1:0] join_pair(input logic [VALUE_W-1:0] a,
                                           input logic [VALUE_W-1:0] b);
      case (mode)
        MODE_MIN: return ($signed(a) < $signed(b)) ? a : b;
        MODE_MAX: return ($signed(a) < $signed(b)) ? b : a;
        default:  return a + b;
      endcase
    endfunction

    // Any register write wipes the store to the identity of the mode then in force.
    function void load_register(input logic idx, input logic [CFG_DATA_W-1:0] data);
      if (idx == REG_COMBINE_MODE) begin
        if (data[1:0] == MODE_SPARE) mode = MODE_SUM;
        else mode = mode_t'(data[1:0]);
      end else begin
        if (data == 0) active_count = 1;
        else if (data > MAX_ENTRIES) active_count = MAX_ENTRIES;
        else active_count = int'(data);
      end
      clear_leaves();
    endfunction

    function void note_word(input item_t w);
      resp_t              r;
      logic [VALUE_W-1:0] acc;
      r.status = STATUS_OK;
      r.result = '0;
      if (w.func == FUNC_UPDATE) begin
        n_update++;
        if (w.first >= active_count) r.status = STATUS_BAD;
        else leaf_value[w.first] = w.value;
      end else begin
        n_query++;
        if (w.last >= active_count || w.first > w.last) begin
          r.status = STATUS_BAD;
        end else begin
          acc = identity();
          for (int i = w.first; i <= w.last; i++) acc = join_pair(acc, leaf_value[i]);
          r.result = acc;
        end
      end
      if (r.status == STATUS_BAD) n_reject++;
      pending_resp.push_back(r);
    endfunction

    function void check_resp(input logic st, input logic [VALUE_W-1:0] val);
      resp_t want;
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d value %h", st, val);
        return;
      end
      want = pending_resp.pop_front();
      n_checked++;
      if (st !== want.status || val !== want.result) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word %0d: expected status %0d value %h, got status %0d value %h",
                   n_checked, want.status, want.result, st, val);
      end
    endfunction

    function int pending();
      return pending_resp.size();
    endfunction

    function void flag_leftover();
      if (pending_resp.size() != 0) begin
        mismatches += pending_resp.size();
        $display("%0d expected result words never arrived", pending_resp.size());
      end
    endfunction
  endclass

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic                       func         = FUNC_UPDATE;
  logic [LEAF_W-1:0]          first_index  = '0;
  logic [LEAF_W-1:0]          last_index   = '0;
  logic signed [VALUE_W-1:0]  new_value    = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic                       status;
  logic signed [VALUE_W-1:0]  result_value;
  logic                       cfg_write_en = 1'b0;
  logic                       cfg_index    = REG_COMBINE_MODE;
  logic [CFG_DATA_W-1:0]      cfg_data     = '0;

  range_combine_checker board = new();
  bit no_gaps = 1'b0;   // forces back-to-back traffic on both sides
  int quiet_cycles = 0;

  // Register plan for phases 1..7; phase 0 runs on the reset values (sum, 1024 entries).
  // Covers the clamp of a zero count and of an oversize count, and the spare mode code.
  logic [CFG_DATA_W-1:0] mode_plan [NUM_PHASES] = '{
    CFG_DATA_W'(MODE_SUM), CFG_DATA_W'(MODE_MIN), {9'h1ff, MODE_SPARE},
    CFG_DATA_W'(MODE_MAX), CFG_DATA_W'(MODE_MIN), {9'h1ff, MODE_MAX},
    CFG_DATA_W'(MODE_SUM), CFG_DATA_W'(MODE_MIN)};
  logic [CFG_DATA_W-1:0] count_plan [NUM_PHASES] = '{
    11'd1024, 11'd0, 11'd2047, 11'd2, 11'd1000, 11'd1024, 11'd37, 11'd1023};

  segment_tree_range_query_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .first_index  (first_index),
    .last_index   (last_index),
    .new_value    (new_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_value (result_value),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitors: sample both handshakes on the rising edge, before any NBA of that edge lands.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      board.note_word(item_t'{func, first_index, last_index, new_value});
    if (!rst && out_valid && !out_stall)
      board.check_resp(status, result_value);
  end

  // Watchdog: any handshake or config write resets the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
      $display("segment_tree_range_query_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : int'($urandom_range(0, 18));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed traffic for an n-entry tree; about one word in ten is raw noise
  // that can land out of range or with first > last.
  function automatic item_t make_word(input int n);
    item_t w;
    int    pick;
    int    lo;
    int    hi;
    int    t;
    pick    = $urandom_range(0, 99);
    w.value = pick_value();
    w.first = LEAF_W'($urandom);
    w.last  = LEAF_W'($urandom);
    if (pick < 10) begin
      w.func = 1'($urandom_range(0, 1));
    end else if (pick < 55) begin
      w.func  = FUNC_UPDATE;
      w.first = (pick < 15) ? LEAF_W'(n - 1) : LEAF_W'($urandom_range(0, n - 1));
    end else begin
      w.func = FUNC_QUERY;
      lo = $urandom_range(0, n - 1);
      hi = $urandom_range(0, n - 1);
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      if (pick >= 92) begin   // whole active span
        lo = 0;
        hi = n - 1;
      end
      w.first = LEAF_W'(lo);
      w.last  = LEAF_W'(hi);
    end
    return w;
  endfunction

  // Present one word and hold it until the core takes it. in_valid is left high so a
  // zero gap keeps the channel streaming without a low/high pair in one step.
  task automatic send_word(input item_t w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= w.func;
    first_index <= w.first;
    last_index  <= w.last;
    new_value   <= w.value;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every outstanding result word has been checked.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Config writes only with the core idle: drained, settled, and ready for input
  // (in_stall low also means any earlier store sweep has finished).
  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    repeat (8) @(posedge clk);
    while (in_stall) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    board.load_register(idx, data);
    cfg_write_en <= 1'b0;
  endtask

  // Result side: stall a drawn number of cycles, then accept one word.
  initial begin
    int stall_len;
    forever begin
      stall_len = draw_gap();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes of index and value, sum wrap, single-leaf and full spans,
    // reversed ranges, ignored fields carrying junk. Reset state is sum over 1024 leaves.
    send_word(item_t'{FUNC_QUERY,  10'd0,    10'd1023, 32'h0000_0000});
    send_word(item_t'{FUNC_UPDATE, 10'd0,    10'd1023, 32'h7fff_ffff});
    send_word(item_t'{FUNC_UPDATE, 10'd1023, 10'd0,    32'h0000_0001});
    send_word(item_t'{FUNC_QUERY,  10'd0,    10'd1023, 32'hffff_ffff});
    send_word(item_t'{FUNC_UPDATE, 10'd512,  10'd511,  32'h8000_0000});
    send_word(item_t'{FUNC_QUERY,  10'd0,    10'd1023, 32'h8000_0000});
    send_word(item_t'{FUNC_QUERY,  10'd1023, 10'd1023, 32'h0});
    send_word(item_t'{FUNC_QUERY,  10'd0,    10'd0,    32'hffff_ffff});
    send_word(item_t'{FUNC_QUERY,  10'd10,   10'd9,    32'h0});
    send_word(item_t'{FUNC_QUERY,  10'd1023, 10'd0,    32'h0});
    send_word(item_t'{FUNC_QUERY,  10'd511,  10'd512,  32'h0});
    send_word(item_t'{FUNC_UPDATE, 10'd1023, 10'd1023, 32'hffff_ffff});
    send_word(item_t'{FUNC_QUERY,  10'd512,  10'd1023, 32'h0});
    send_word(item_t'{FUNC_UPDATE, 10'd0,    10'd0,    32'h0000_0000});
    send_word(item_t'{FUNC_QUERY,  10'd0,    10'd511,  32'h5555_aaaa});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        write_reg(REG_COMBINE_MODE, mode_plan[ph]);
        write_reg(REG_ACTIVE_ENTRIES, count_plan[ph]);
      end
      n = board.active_count;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // a back-to-back stretch in every phase
        no_gaps = (k >= 60 && k < 80);
        // hold off the sender once until everything in flight is back
        if (ph == 3 && k == 40) drain_results();
        send_word(make_word(n));
      end
      no_gaps = 1'b0;
    end

    drain_results();
    repeat (64) @(posedge clk);
    board.flag_leftover();

    $display("covered %0d register settings: %0d updates, %0d queries, %0d rejected words",
             NUM_PHASES, board.n_update, board.n_query, board.n_reject);
    $display("%0d result words checked, %0d mismatches", board.n_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("segment_tree_range_query_core test passed");
    end else begin
      $display("segment_tree_range_query_core test failed");
    end
    $finish;
  end

endmodule

/* segment_tree_range_query_core.f */
+incdir+design
design/stq_pkg.sv
design/stq_join.sv
design/stq_node_ram.sv
design/stq_ctrl.sv
design/segment_tree_range_query_core.sv
bench/segment_tree_range_query_core_tb.sv
